>>> design/lsb_pixel_payload_embedder_macros.svh
// ----------------------------------------------------------------------------
// LSB pixel payload embedder: assertion macros
// Concurrent assertion shorthands clocked on a rising edge, reset active low.
// ----------------------------------------------------------------------------
`ifndef LSB_PIXEL_PAYLOAD_EMBEDDER_MACROS_SVH
`define LSB_PIXEL_PAYLOAD_EMBEDDER_MACROS_SVH

// same-cycle implication, antecedent and consequent given as one property
`define LSBE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// next-cycle implication
`define LSBE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lsbe_pkg.sv
// ----------------------------------------------------------------------------
// lsbe_pkg
// Shared types and constants of the LSB pixel payload embedder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsbe_pkg;

    localparam int MAX_SIG_BYTES = 12;
    localparam int PIX_W         = 24;
    localparam int K_W           = 3;
    localparam int CNT_W         = 4;
    localparam int Q_W           = 16;
    localparam int SIG_IDX_W     = 4;
    localparam int LEN_W         = 32;
    localparam int TAKEN_W       = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [7:0]     HDR_KEEP_MASK = 8'hF8;
    localparam logic [K_W-1:0] HDR_RED_TAG   = 3'd0;
    localparam logic [K_W-1:0] HDR_GREEN_TAG = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BITS_PER_CHANNEL = 3'd0,
        CFG_PAYLOAD_LENGTH   = 3'd1,
        CFG_SIGNATURE_LOW    = 3'd2,
        CFG_SIGNATURE_HIGH   = 3'd3,
        CFG_SIGNATURE_LENGTH = 3'd4
    } cfg_index_t;

    // embedding state as it moves from channel to channel
    typedef struct packed {
        logic [Q_W-1:0]       queue;
        logic [CNT_W-1:0]     count;
        logic [SIG_IDX_W-1:0] sig_idx;
        logic [TAKEN_W-1:0]   taken;
    } lsbe_state_t;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [K_W-1:0]                  k;
        logic [LEN_W-1:0]                payload_length;
        logic [MAX_SIG_BYTES-1:0][7:0]   sig_bytes;
        logic [SIG_IDX_W-1:0]            sig_len;
    } lsbe_cfg_t;

endpackage

>>> design/lsbe_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsbe_cfg_regs
// Configuration register file; presents clamped K and signature length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsbe_cfg_regs
    import lsbe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output lsbe_cfg_t             cfg
);

    logic [K_W-1:0]       bpc_reg;
    logic [LEN_W-1:0]     plen_reg;
    logic [63:0]          sig_lo_reg;
    logic [31:0]          sig_hi_reg;
    logic [SIG_IDX_W-1:0] sig_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpc_reg     <= K_W'(1);
            plen_reg    <= '0;
            sig_lo_reg  <= '0;
            sig_hi_reg  <= '0;
            sig_len_reg <= SIG_IDX_W'(MAX_SIG_BYTES);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BITS_PER_CHANNEL: bpc_reg     <= cfg_data[K_W-1:0];
                CFG_PAYLOAD_LENGTH:   plen_reg    <= cfg_data[LEN_W-1:0];
                CFG_SIGNATURE_LOW:    sig_lo_reg  <= cfg_data[63:0];
                CFG_SIGNATURE_HIGH:   sig_hi_reg  <= cfg_data[31:0];
                CFG_SIGNATURE_LENGTH: sig_len_reg <= cfg_data[SIG_IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.k              = (bpc_reg == '0) ? K_W'(1) : bpc_reg;
        cfg.payload_length = plen_reg;
        cfg.sig_bytes      = {sig_hi_reg, sig_lo_reg};
        if (sig_len_reg == '0) begin
            cfg.sig_len = SIG_IDX_W'(1);
        end else if (sig_len_reg > SIG_IDX_W'(MAX_SIG_BYTES)) begin
            cfg.sig_len = SIG_IDX_W'(MAX_SIG_BYTES);
        end else begin
            cfg.sig_len = sig_len_reg;
        end
    end

endmodule

>>> design/lsbe_chan_step.sv
// ----------------------------------------------------------------------------
// lsbe_chan_step
// One color channel: refill the bit queue if short, splice K bits in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsbe_chan_step
    import lsbe_pkg::*;
(
    input  lsbe_state_t     st_in,
    input  lsbe_cfg_t       cfg,
    input  logic [2:0]      rem_gt,
    input  logic [2:0][7:0] pay_bytes,
    input  logic [7:0]      chan_in,
    output lsbe_state_t     st_out,
    output logic [7:0]      chan_out
);

    logic                 need;
    logic                 use_pay;
    logic [7:0]           pay;
    logic [SIG_IDX_W-1:0] sidx;
    logic [SIG_IDX_W-1:0] sinc;
    logic [7:0]           sbyte;
    logic [7:0]           new_byte;
    logic [Q_W-1:0]       q;
    logic [CNT_W-1:0]     cnt;
    logic [7:0]           mask;
    logic [7:0]           bits;

    always_comb begin
        need = st_in.count < {1'b0, cfg.k};
        unique case (st_in.taken)
            2'd0: begin
                use_pay = rem_gt[0];
                pay     = pay_bytes[0];
            end
            2'd1: begin
                use_pay = rem_gt[1];
                pay     = pay_bytes[1];
            end
            2'd2: begin
                use_pay = rem_gt[2];
                pay     = pay_bytes[2];
            end
            default: begin
                use_pay = 1'b0;
                pay     = pay_bytes[2];
            end
        endcase

        sidx     = (st_in.sig_idx < cfg.sig_len) ? st_in.sig_idx : '0;
        sbyte    = cfg.sig_bytes[sidx];
        sinc     = sidx + SIG_IDX_W'(1);
        new_byte = use_pay ? pay : sbyte;

        st_out = st_in;
        q      = st_in.queue;
        cnt    = st_in.count;
        if (need) begin
            q   = q | ({8'h00, new_byte} << (CNT_W'(8) - cnt));
            cnt = cnt + CNT_W'(8);
            if (use_pay) begin
                st_out.taken = st_in.taken + TAKEN_W'(1);
            end else begin
                st_out.sig_idx = (sinc >= cfg.sig_len) ? '0 : sinc;
            end
        end

        mask         = (8'h01 << cfg.k) - 8'h01;
        bits         = 8'(q >> (5'd16 - {2'b00, cfg.k})) & mask;
        chan_out     = (chan_in & ~mask) | bits;
        st_out.queue = q << cfg.k;
        st_out.count = cnt - {1'b0, cfg.k};
    end

endmodule

>>> design/lsbe_embed_stage.sv
// ----------------------------------------------------------------------------
// lsbe_embed_stage
// Embedding state, three chained channel steps and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsbe_embed_stage
    import lsbe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  lsbe_cfg_t          cfg,
    input  logic               in_valid,
    output logic               in_take,
    input  logic [PIX_W-1:0]   in_pixel,
    input  logic               in_first,
    input  logic [2:0][7:0]    in_pay,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIX_W-1:0]   m_stego_pixel,
    output logic [TAKEN_W-1:0] m_bytes_taken
);

    logic [Q_W-1:0]       queue_reg,    queue_next;
    logic [CNT_W-1:0]     count_reg,    count_next;
    logic [LEN_W-1:0]     consumed_reg, consumed_next;
    logic [SIG_IDX_W-1:0] sig_idx_reg,  sig_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]     pixel_reg,    pixel_next;
    logic [TAKEN_W-1:0]   taken_reg,    taken_next;

    logic [LEN_W-1:0]     remain;
    logic [2:0]           rem_gt;
    lsbe_state_t          st0, st1, st2, st3;
    logic [7:0]           r_emb, g_emb, b_emb;

    assign in_take = in_valid && (!out_valid_reg || m_ready);

    always_comb begin
        remain    = cfg.payload_length - consumed_reg;
        rem_gt[0] = cfg.payload_length > consumed_reg;
        rem_gt[1] = rem_gt[0] && (remain > LEN_W'(1));
        rem_gt[2] = rem_gt[0] && (remain > LEN_W'(2));
        st0       = '{queue: queue_reg, count: count_reg, sig_idx: sig_idx_reg, taken: '0};
    end

    lsbe_chan_step u_red (
        .st_in     (st0),
        .cfg       (cfg),
        .rem_gt    (rem_gt),
        .pay_bytes (in_pay),
        .chan_in   (in_pixel[7:0]),
        .st_out    (st1),
        .chan_out  (r_emb)
    );

    lsbe_chan_step u_green (
        .st_in     (st1),
        .cfg       (cfg),
        .rem_gt    (rem_gt),
        .pay_bytes (in_pay),
        .chan_in   (in_pixel[15:8]),
        .st_out    (st2),
        .chan_out  (g_emb)
    );

    lsbe_chan_step u_blue (
        .st_in     (st2),
        .cfg       (cfg),
        .rem_gt    (rem_gt),
        .pay_bytes (in_pay),
        .chan_in   (in_pixel[23:16]),
        .st_out    (st3),
        .chan_out  (b_emb)
    );

    always_comb begin
        queue_next     = queue_reg;
        count_next     = count_reg;
        consumed_next  = consumed_reg;
        sig_idx_next   = sig_idx_reg;
        pixel_next     = pixel_reg;
        taken_next     = taken_reg;
        out_valid_next = m_ready ? 1'b0 : out_valid_reg;
        if (in_take) begin
            out_valid_next = 1'b1;
            if (in_first) begin
                queue_next    = '0;
                count_next    = '0;
                consumed_next = '0;
                sig_idx_next  = '0;
                taken_next    = '0;
                pixel_next    = {in_pixel[23:16] & HDR_KEEP_MASK | {5'b0, cfg.k},
                                 in_pixel[15:8]  & HDR_KEEP_MASK | {5'b0, HDR_GREEN_TAG},
                                 in_pixel[7:0]   & HDR_KEEP_MASK | {5'b0, HDR_RED_TAG}};
            end else begin
                queue_next    = st3.queue;
                count_next    = st3.count;
                sig_idx_next  = st3.sig_idx;
                consumed_next = consumed_reg + LEN_W'(st3.taken);
                taken_next    = st3.taken;
                pixel_next    = {b_emb, g_emb, r_emb};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queue_reg     <= '0;
            count_reg     <= '0;
            consumed_reg  <= '0;
            sig_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            queue_reg     <= queue_next;
            count_reg     <= count_next;
            consumed_reg  <= consumed_next;
            sig_idx_reg   <= sig_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pixel_reg <= pixel_next;
        taken_reg <= taken_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_stego_pixel = pixel_reg;
    assign m_bytes_taken = taken_reg;

endmodule

>>> design/lsb_pixel_payload_embedder.sv
// ----------------------------------------------------------------------------
// lsb_pixel_payload_embedder
// Hides a byte payload, then a repeating signature, in the low K bits of
// each color channel of an RGB pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries cover pixels with the three payload bytes at the producer's
//   current position; m_* returns the stego pixel and the number of payload
//   bytes used, by which the producer advances before offering the next pixel.
//   A pixel with s_first_pixel set clears the embedding state and comes back
//   as a header pixel (low bits 0, 3 and K in red, green and blue).
//   cfg_* writes the five configuration registers by index; writes are always
//   accepted and belong to idle periods.
//   The result passes the input register, then the result register, to m_*.
//   Throughput: one pixel per cycle while m_ready is high, state updated as each pixel is embedded.
//   Reset clears the embedding state and both stages and loads the register
//   defaults. When m_ready is low the result holds, the input register takes
//   one more pixel, and s_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsb_pixel_payload_embedder
    import lsbe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_cover_pixel,
    input  logic                  s_first_pixel,
    input  logic [7:0]            s_payload_byte_0,
    input  logic [7:0]            s_payload_byte_1,
    input  logic [7:0]            s_payload_byte_2,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_stego_pixel,
    output logic [TAKEN_W-1:0]    m_bytes_taken
);

    lsbe_cfg_t        cfg;
    logic             in_take;
    logic             in_valid_reg, in_valid_next;
    logic [PIX_W-1:0] pixel_reg;
    logic             first_reg;
    logic [2:0][7:0]  pay_reg;
    logic             s_xfer;

    lsbe_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_ready = !in_valid_reg || in_take;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (in_take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pixel_reg <= s_cover_pixel;
            first_reg <= s_first_pixel;
            pay_reg   <= {s_payload_byte_2, s_payload_byte_1, s_payload_byte_0};
        end
    end

    lsbe_embed_stage u_embed (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .in_valid      (in_valid_reg),
        .in_take       (in_take),
        .in_pixel      (pixel_reg),
        .in_first      (first_reg),
        .in_pay        (pay_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_stego_pixel (m_stego_pixel),
        .m_bytes_taken (m_bytes_taken)
    );

endmodule

>>> design/lsbe_checker.sv
// ----------------------------------------------------------------------------
// lsbe_checker
// Port-level checks of the embedder's flow control, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lsb_pixel_payload_embedder_macros.svh"

module lsbe_checker
    import lsbe_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [PIX_W-1:0]      m_stego_pixel,
    input logic [TAKEN_W-1:0]    m_bytes_taken
);

    // stalled result holds
    `LSBE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_stego_pixel) && $stable(m_bytes_taken), "result changed while stalled")

    // input backpressure only comes from a stalled, full output
    `LSBE_ASSERT(a_ready_cause, aclk, aresetn, !s_ready |-> (m_valid && !m_ready), "input stalled without output stall")

    // a transfer while no result is offered shows up after the input and result registers
    `LSBE_ASSERT(a_latency, aclk, aresetn, (s_valid && s_ready && !m_valid) |-> ##2 m_valid, "result missing two cycles after transfer")

endmodule

bind lsb_pixel_payload_embedder lsbe_checker u_lsbe_checker (.*);
